// ===== src/avr_pkg.sv =====
// Shared constants and types for the axis vector rotator.
// No dependencies; every other file imports this package.
package avr_pkg;

    // Default configuration of the top level.
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int ANGLE_WIDTH_DEF      = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    // Mode field: axis in the upper two bits, clockwise, right handed.
    localparam int MODE_WIDTH = 4;

    // Sine and cosine are signed Q1.15.
    localparam int TRIG_WIDTH = 16;
    localparam int TRIG_FRAC  = 15;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

endpackage

// ===== src/axis_vector_rotator.sv =====
// Top level of the axis vector rotator: input stage, table lookup, rotation, result stage.
// Depends on avr_pkg, avr_sincos and avr_rotate.
//
//  channel   handshake          payload                         direction
//  -------   ----------------   -----------------------------   ---------
//  command   start / busy       mode, x_in, y_in, z_in, angle   in
//  result    done (strobe)      x_out, y_out, z_out, clipped    out
//
// A word is taken at each rising edge with start high; busy is always low,
// so one word enters every cycle. Two register stages: the input stage holds
// the in-plane pair, the axis coordinate and the table sine and cosine; the
// result stage holds the rotated, rounded and saturated vector. done is high
// for one cycle per word, registered from the input stage valid flag; the
// product and round path of the result stage sets the clock. Reset (rst_n low,
// async) clears the valid flags and sets the input stage axis code to AXIS_NONE
// only. The receiver cannot stall, so nothing holds.
module axis_vector_rotator
    import avr_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH      = ANGLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [MODE_WIDTH-1:0]         mode,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic signed [COORD_WIDTH-1:0] z_in,
    input  logic [ANGLE_WIDTH-1:0]        angle,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic signed [COORD_WIDTH-1:0] z_out,
    output logic                          clipped
);

    // ---------------- input stage ----------------
    axis_t                        in_axis;
    logic signed [COORD_WIDTH-1:0] s1_u_next;
    logic signed [COORD_WIDTH-1:0] s1_v_next;
    logic signed [COORD_WIDTH-1:0] s1_w_next;
    logic signed [TRIG_WIDTH-1:0]  s1_sin_next;
    logic signed [TRIG_WIDTH-1:0]  s1_cos_next;

    logic                          s1_valid_reg;
    axis_t                         s1_axis_reg;
    logic signed [COORD_WIDTH-1:0] s1_u_reg;
    logic signed [COORD_WIDTH-1:0] s1_v_reg;
    logic signed [COORD_WIDTH-1:0] s1_w_reg;
    logic signed [TRIG_WIDTH-1:0]  s1_sin_reg;
    logic signed [TRIG_WIDTH-1:0]  s1_cos_reg;

    assign in_axis = axis_t'(mode[MODE_WIDTH-1 -: 2]);
    assign busy    = 1'b0;

    // Pick the rotation plane (u, v) and the axis coordinate w.
    // With no axis, carry x, y, z straight through as u, v, w.
    always_comb
    begin
        unique case (in_axis)
            AXIS_X:
            begin
                s1_u_next = y_in;
                s1_v_next = z_in;
                s1_w_next = x_in;
            end
            AXIS_Y:
            begin
                s1_u_next = z_in;
                s1_v_next = x_in;
                s1_w_next = y_in;
            end
            AXIS_Z:
            begin
                s1_u_next = x_in;
                s1_v_next = y_in;
                s1_w_next = z_in;
            end
            AXIS_NONE:
            begin
                s1_u_next = x_in;
                s1_v_next = y_in;
                s1_w_next = z_in;
            end
        endcase
    end

    // Clockwise xor right handed reverses the angle.
    avr_sincos #(
        .ANGLE_WIDTH      (ANGLE_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sincos (
        .angle   (angle),
        .reverse (mode[1] ^ mode[0]),
        .sin_val (s1_sin_next),
        .cos_val (s1_cos_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_axis_reg  <= AXIS_NONE;
        end
        else
        begin
            s1_valid_reg <= start;
            s1_axis_reg  <= in_axis;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_u_reg    <= s1_u_next;
        s1_v_reg    <= s1_v_next;
        s1_w_reg    <= s1_w_next;
        s1_sin_reg  <= s1_sin_next;
        s1_cos_reg  <= s1_cos_next;
    end

    // ---------------- result stage ----------------
    logic signed [COORD_WIDTH-1:0] rot_u;
    logic signed [COORD_WIDTH-1:0] rot_v;
    logic                          rot_sat;

    logic signed [COORD_WIDTH-1:0] x_out_next;
    logic signed [COORD_WIDTH-1:0] y_out_next;
    logic signed [COORD_WIDTH-1:0] z_out_next;
    logic                          clipped_next;

    logic                          done_reg;
    logic signed [COORD_WIDTH-1:0] x_out_reg;
    logic signed [COORD_WIDTH-1:0] y_out_reg;
    logic signed [COORD_WIDTH-1:0] z_out_reg;
    logic                          clipped_reg;

    avr_rotate #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rotate (
        .u       (s1_u_reg),
        .v       (s1_v_reg),
        .sin_val (s1_sin_reg),
        .cos_val (s1_cos_reg),
        .nu      (rot_u),
        .nv      (rot_v),
        .sat     (rot_sat)
    );

    // Put the rotated pair back in place; the axis coordinate never clips.
    always_comb
    begin
        clipped_next = rot_sat;
        unique case (s1_axis_reg)
            AXIS_X:
            begin
                x_out_next = s1_w_reg;
                y_out_next = rot_u;
                z_out_next = rot_v;
            end
            AXIS_Y:
            begin
                x_out_next = rot_v;
                y_out_next = s1_w_reg;
                z_out_next = rot_u;
            end
            AXIS_Z:
            begin
                x_out_next = rot_u;
                y_out_next = rot_v;
                z_out_next = s1_w_reg;
            end
            AXIS_NONE:
            begin
                x_out_next   = s1_u_reg;
                y_out_next   = s1_v_reg;
                z_out_next   = s1_w_reg;
                clipped_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        x_out_reg   <= x_out_next;
        y_out_reg   <= y_out_next;
        z_out_reg   <= z_out_next;
        clipped_reg <= clipped_next;
    end

    assign done    = done_reg;
    assign x_out   = x_out_reg;
    assign y_out   = y_out_reg;
    assign z_out   = z_out_reg;
    assign clipped = clipped_reg;

    // ---------------- checks ----------------
    // Every accepted word yields a result strobe after the input and result stages.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
        else $error("accepted word produced no result strobe");

    // No result strobe without a word held in the input stage before it.
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg))
        else $error("result strobe without a word in the input stage");

    // Words with no axis pass through untouched and never flag clipping.
    a_no_axis_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(s1_axis_reg) == AXIS_NONE) |->
            !clipped && (x_out == $past(s1_u_reg)) && (y_out == $past(s1_v_reg))
            && (z_out == $past(s1_w_reg)))
        else $error("pass-through word was altered");

endmodule

// ===== src/avr_sincos.sv =====
// Sine and cosine lookup from a quarter-wave Q1.15 table built at elaboration.
// Depends on avr_pkg.
module avr_sincos
    import avr_pkg::*;
#(
    parameter int ANGLE_WIDTH      = ANGLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
)
(
    input  logic [ANGLE_WIDTH-1:0]       angle,
    input  logic                         reverse,
    output logic signed [TRIG_WIDTH-1:0] sin_val,
    output logic signed [TRIG_WIDTH-1:0] cos_val
);

    localparam int PW = ANGLE_WIDTH - 2;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MW = PW + IW;

    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 9;
    localparam logic [8:0]  TAYLOR_DIV [1:9] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342
    };

    // Entry i is sin(i/DEPTH * pi/2) from a Q2.30 Taylor series, rounded to Q1.15.
    function automatic logic [TRIG_WIDTH-2:0] sine_q15(input int unsigned idx);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        logic [3:0]         k;
        x    = (HALF_PI_Q30 * 64'(idx)) / 64'(SINE_TABLE_DEPTH);
        term = x;
        sum  = signed'(x);
        for (k = 4'd1; k <= 4'(TAYLOR_TERMS); k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'(TAYLOR_DIV[k]);
            if (k[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum + 64'sd16384) >>> TRIG_FRAC;
        if (r > 64'sd32767)
            r = 64'sd32767;
        return r[TRIG_WIDTH-2:0];
    endfunction

    logic [TRIG_WIDTH-2:0] sine_rom [0:SINE_TABLE_DEPTH];

    for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++)
    begin : g_rom
        assign sine_rom[i] = sine_q15(i);
    end

    logic [ANGLE_WIDTH-1:0]       eff_angle;
    logic [1:0]                   quad;
    logic [MW-1:0]                scaled;
    logic [IW-1:0]                idx;
    logic [IW-1:0]                idx_comp;
    logic signed [TRIG_WIDTH-1:0] ta;
    logic signed [TRIG_WIDTH-1:0] tb;

    // Negate the angle for the reversed sense.
    assign eff_angle = reverse ? (ANGLE_WIDTH'(0) - angle) : angle;
    assign quad      = eff_angle[ANGLE_WIDTH-1 -: 2];
    assign scaled    = MW'(eff_angle[PW-1:0]) * MW'(SINE_TABLE_DEPTH);
    assign idx       = scaled[MW-1:PW];
    assign idx_comp  = IW'(SINE_TABLE_DEPTH) - idx;
    assign ta        = signed'({1'b0, sine_rom[idx]});
    assign tb        = signed'({1'b0, sine_rom[idx_comp]});

    always_comb
    begin
        case (quad)
            2'd0:
            begin
                sin_val = ta;
                cos_val = tb;
            end
            2'd1:
            begin
                sin_val = tb;
                cos_val = -ta;
            end
            2'd2:
            begin
                sin_val = -ta;
                cos_val = -tb;
            end
            default:
            begin
                sin_val = -tb;
                cos_val = ta;
            end
        endcase
    end

endmodule

// ===== src/avr_rotate.sv =====
// Plane rotation datapath: four products, round half up to Q16.0, saturate.
// Depends on avr_pkg.
module avr_rotate
    import avr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic signed [COORD_WIDTH-1:0] u,
    input  logic signed [COORD_WIDTH-1:0] v,
    input  logic signed [TRIG_WIDTH-1:0]  sin_val,
    input  logic signed [TRIG_WIDTH-1:0]  cos_val,
    output logic signed [COORD_WIDTH-1:0] nu,
    output logic signed [COORD_WIDTH-1:0] nv,
    output logic                          sat
);

    localparam int PW = COORD_WIDTH + TRIG_WIDTH;
    localparam int SW = PW + 1;
    localparam int RW = SW + 1;
    localparam int OW = RW - TRIG_FRAC;

    localparam logic signed [RW-1:0] HALF = RW'(1) <<< (TRIG_FRAC - 1);
    localparam logic signed [OW-1:0] HI   =
        {{(OW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [OW-1:0] LO   =
        {{(OW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    // Arithmetic shift right after adding one half rounds half up.
    function automatic logic signed [OW-1:0] round_q(input logic signed [SW-1:0] s);
        logic signed [RW-1:0] t;
        t = RW'(s) + HALF;
        return t[RW-1:TRIG_FRAC];
    endfunction

    logic signed [PW-1:0] p_uc;
    logic signed [PW-1:0] p_vs;
    logic signed [PW-1:0] p_us;
    logic signed [PW-1:0] p_vc;
    logic signed [SW-1:0] sum_u;
    logic signed [SW-1:0] sum_v;
    logic signed [OW-1:0] r_u;
    logic signed [OW-1:0] r_v;
    logic                 hi_u;
    logic                 lo_u;
    logic                 hi_v;
    logic                 lo_v;

    assign p_uc  = PW'(u) * PW'(cos_val);
    assign p_vs  = PW'(v) * PW'(sin_val);
    assign p_us  = PW'(u) * PW'(sin_val);
    assign p_vc  = PW'(v) * PW'(cos_val);
    assign sum_u = SW'(p_uc) - SW'(p_vs);
    assign sum_v = SW'(p_us) + SW'(p_vc);
    assign r_u   = round_q(sum_u);
    assign r_v   = round_q(sum_v);

    assign hi_u = r_u > HI;
    assign lo_u = r_u < LO;
    assign hi_v = r_v > HI;
    assign lo_v = r_v < LO;

    assign nu  = hi_u ? HI[COORD_WIDTH-1:0] : (lo_u ? LO[COORD_WIDTH-1:0] : r_u[COORD_WIDTH-1:0]);
    assign nv  = hi_v ? HI[COORD_WIDTH-1:0] : (lo_v ? LO[COORD_WIDTH-1:0] : r_v[COORD_WIDTH-1:0]);
    assign sat = hi_u | lo_u | hi_v | lo_v;

endmodule

// ===== verif/avr_checker.sv =====
// Checker for the axis vector rotator: predicts each rotated word and compares it.
// Depends on avr_pkg; instantiated by tb beside the block.
module avr_checker
    import avr_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH      = ANGLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [MODE_WIDTH-1:0]         mode,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic signed [COORD_WIDTH-1:0] z_in,
    input  logic [ANGLE_WIDTH-1:0]        angle,
    input  logic                          done,
    input  logic signed [COORD_WIDTH-1:0] x_out,
    input  logic signed [COORD_WIDTH-1:0] y_out,
    input  logic signed [COORD_WIDTH-1:0] z_out,
    input  logic                          clipped,
    output int                            bad_vectors,
    output int                            vectors_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          clip;
    } rotated_vec_t;

    localparam int     CW_BIT        = 1;
    localparam int     RH_BIT        = 0;
    localparam int     TAYLOR_TERMS  = 9;
    localparam u64_t   HALF_PI_Q30   = 64'd1686629713;
    localparam longint TRIG_MAX      = (longint'(1) << TRIG_FRAC) - 1;
    localparam longint TRIG_HALF     = longint'(1) << (TRIG_FRAC - 1);
    localparam longint COORD_MAX     = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN     = -COORD_MAX - 1;

    rotated_vec_t pending_rotations[$];

    // Quarter-wave sine in Q1.15, evaluated as a Q2.30 Taylor series.
    function automatic longint quarter_sine(u64_t idx);
        u64_t   phase;
        u64_t   term;
        longint sum;
        if (idx > SINE_TABLE_DEPTH)
            idx = SINE_TABLE_DEPTH;
        phase = (HALF_PI_Q30 * idx) / u64_t'(SINE_TABLE_DEPTH);
        term  = phase;
        sum   = longint'(phase);
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = (term * phase) >> 30;
            term = (term * phase) >> 30;
            term = term / u64_t'((2 * k) * (2 * k + 1));
            if (k % 2)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + TRIG_HALF) >>> TRIG_FRAC;
        return (sum > TRIG_MAX) ? TRIG_MAX : sum;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic rotated_vec_t rotate_about_axis(
        logic [MODE_WIDTH-1:0]         m,
        logic signed [COORD_WIDTH-1:0] xi,
        logic signed [COORD_WIDTH-1:0] yi,
        logic signed [COORD_WIDTH-1:0] zi,
        logic [ANGLE_WIDTH-1:0]        ang
    );
        rotated_vec_t           r;
        axis_t                  axis;
        logic [ANGLE_WIDTH-1:0] a;
        u64_t                   idx;
        longint                 ta, tb, sn, cs, u, v, nu, nv;
        longint                 coord [3];
        int                     ui, vi;
        axis     = axis_t'(m[MODE_WIDTH-1 -: 2]);
        coord[0] = xi;
        coord[1] = yi;
        coord[2] = zi;
        r.clip   = 1'b0;
        if (axis != AXIS_NONE)
        begin
            // Negate the angle for clockwise xor right handed.
            a = ang;
            if (m[CW_BIT] ^ m[RH_BIT])
                a = -ang;
            idx = (u64_t'(a[ANGLE_WIDTH-3:0]) * SINE_TABLE_DEPTH) >> (ANGLE_WIDTH - 2);
            ta  = quarter_sine(idx);
            tb  = quarter_sine(SINE_TABLE_DEPTH - idx);
            case (a[ANGLE_WIDTH-1 -: 2])
                2'd0:    begin sn =  ta; cs =  tb; end
                2'd1:    begin sn =  tb; cs = -ta; end
                2'd2:    begin sn = -ta; cs = -tb; end
                default: begin sn = -tb; cs =  ta; end
            endcase
            case (axis)
                AXIS_X:  begin ui = 1; vi = 2; end
                AXIS_Y:  begin ui = 2; vi = 0; end
                default: begin ui = 0; vi = 1; end
            endcase
            u  = coord[ui];
            v  = coord[vi];
            nu = (u * cs - v * sn + TRIG_HALF) >>> TRIG_FRAC;
            nv = (u * sn + v * cs + TRIG_HALF) >>> TRIG_FRAC;
            r.clip = (clamp_coord(nu) != nu) || (clamp_coord(nv) != nv);
            coord[ui] = clamp_coord(nu);
            coord[vi] = clamp_coord(nv);
        end
        r.x = coord[0][COORD_WIDTH-1:0];
        r.y = coord[1][COORD_WIDTH-1:0];
        r.z = coord[2][COORD_WIDTH-1:0];
        return r;
    endfunction

    function automatic void note_bad_word(string what);
        if (bad_vectors < 10)
            $display("%0t ns: %s", $realtime, what);
        bad_vectors++;
    endfunction

    // Compare before pushing: a word passes the input and result stage registers,
    // so a word accepted at this edge is never the one finishing here.
    always @(posedge clk)
    begin
        rotated_vec_t want;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                if (pending_rotations.size() == 0)
                    note_bad_word($sformatf("unexpected word x=%0d y=%0d z=%0d clipped=%0b",
                                            x_out, y_out, z_out, clipped));
                else
                begin
                    want = pending_rotations.pop_front();
                    if (x_out !== want.x || y_out !== want.y || z_out !== want.z
                        || clipped !== want.clip)
                        note_bad_word($sformatf(
                            {"mismatch: expected x=%0d y=%0d z=%0d clipped=%0b, ",
                             "got x=%0d y=%0d z=%0d clipped=%0b"},
                            want.x, want.y, want.z, want.clip,
                            x_out, y_out, z_out, clipped));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                pending_rotations.push_back(rotate_about_axis(mode, x_in, y_in, z_in, angle));
            vectors_in_flight <= pending_rotations.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the axis vector rotator: clock, reset, stimulus and verdict.
// Depends on avr_pkg, axis_vector_rotator and avr_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import avr_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int AW = ANGLE_WIDTH_DEF;

    localparam logic signed [CW-1:0] COORD_TOP    = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_BOTTOM = {1'b1, {(CW-1){1'b0}}};
    localparam logic [AW-1:0]        QUARTER      = AW'(1) << (AW - 2);
    localparam int                   RANDOM_WORDS = 800;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [MODE_WIDTH-1:0] mode;
    logic signed [CW-1:0] x_in, y_in, z_in;
    logic [AW-1:0]        angle;
    logic                 done;
    logic signed [CW-1:0] x_out, y_out, z_out;
    logic                 clipped;
    int                   bad_vectors;
    int                   vectors_in_flight;

    always #2 clk = ~clk;

    axis_vector_rotator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .mode    (mode),
        .x_in    (x_in),
        .y_in    (y_in),
        .z_in    (z_in),
        .angle   (angle),
        .done    (done),
        .x_out   (x_out),
        .y_out   (y_out),
        .z_out   (z_out),
        .clipped (clipped)
    );

    // The checker watches both channels on its own; the top only drives words
    // and reads back the failure count and how many words are still in flight.
    avr_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .x_in              (x_in),
        .y_in              (y_in),
        .z_in              (z_in),
        .angle             (angle),
        .done              (done),
        .x_out             (x_out),
        .y_out             (y_out),
        .z_out             (z_out),
        .clipped           (clipped),
        .bad_vectors       (bad_vectors),
        .vectors_in_flight (vectors_in_flight)
    );

    // Mode layout: axis in the upper two bits, then clockwise, then right handed.
    function automatic logic [MODE_WIDTH-1:0] make_mode(axis_t ax, bit cw, bit rh);
        return {ax, cw, rh};
    endfunction

    // Weight coordinates toward the extremes and small values; the rest is
    // full range so every bit toggles and large vectors hit saturation.
    function automatic logic signed [CW-1:0] random_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return COORD_TOP;
                    1:       return COORD_BOTTOM;
                    2:       return '0;
                    3:       return 1;
                    default: return '1;
                endcase
            end
            1, 2:    return CW'(int'($urandom_range(0, 8192)) - 4096);
            default: return CW'($urandom);
        endcase
    endfunction

    // Mostly full-range angles; the rest sit on and next to quadrant edges,
    // where the table index wraps and the sign of sine and cosine flips.
    function automatic logic [AW-1:0] random_angle();
        logic [AW-1:0] edge_angle;
        if ($urandom_range(0, 4) != 0)
            return AW'($urandom);
        edge_angle = AW'(QUARTER * $urandom_range(0, 3));
        return AW'(edge_angle + $urandom_range(0, 2) - 1);
    endfunction

    // Mostly real rotations; now and then the no-rotation axis code.
    function automatic logic [MODE_WIDTH-1:0] random_mode();
        axis_t ax;
        if ($urandom_range(0, 7) == 0)
            ax = AXIS_NONE;
        else
            ax = axis_t'($urandom_range(0, 2));
        return make_mode(ax, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Present one word at the current edge and hold it until the edge that
    // takes it. Returns on that edge, so the next word can follow directly
    // with start still high.
    task automatic send_word(
        input logic [MODE_WIDTH-1:0] m,
        input logic signed [CW-1:0]  xv,
        input logic signed [CW-1:0]  yv,
        input logic signed [CW-1:0]  zv,
        input logic [AW-1:0]         av
    );
        start <= 1'b1;
        mode  <= m;
        x_in  <= xv;
        y_in  <= yv;
        z_in  <= zv;
        angle <= av;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Drop start and hold off for a number of cycles.
    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start and wait for every outstanding word to come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (vectors_in_flight != 0);
    endtask

    initial
    begin
        int burst_left;
        int gap;

        rst_n <= 1'b0;
        start <= 1'b0;
        mode  <= '0;
        x_in  <= '0;
        y_in  <= '0;
        z_in  <= '0;
        angle <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every axis, sense and handedness at a quarter turn.
        for (int ax = AXIS_X; ax <= AXIS_Z; ax++)
            for (int cw = 0; cw < 2; cw++)
                for (int rh = 0; rh < 2; rh++)
                    send_word(make_mode(axis_t'(ax), 1'(cw), 1'(rh)), 4096, 8192, -4096,
                              QUARTER);

        // Full-scale vectors at odd eighths of a turn: the in-plane pair
        // grows by root two and must saturate, the axis coordinate must not.
        send_word(make_mode(AXIS_Z, 0, 0), COORD_TOP, COORD_TOP, COORD_TOP,
                  AW'(QUARTER / 2));
        send_word(make_mode(AXIS_X, 1, 0), COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM,
                  AW'(QUARTER / 2));
        send_word(make_mode(AXIS_Y, 0, 1), COORD_TOP, COORD_BOTTOM, COORD_TOP,
                  AW'(3 * QUARTER / 2));

        // Half and three-quarter turns, the last step before a full turn, one step.
        send_word(make_mode(AXIS_Z, 0, 0), 12345, -2345, 777, AW'(2 * QUARTER));
        send_word(make_mode(AXIS_Z, 0, 0), 12345, -2345, 777, AW'(3 * QUARTER));
        send_word(make_mode(AXIS_Z, 0, 0), 12345, -2345, 777, '1);
        send_word(make_mode(AXIS_Z, 0, 0), 12345, -2345, 777, 1);

        // No-rotation axis code: the vector passes through untouched.
        send_word(make_mode(AXIS_NONE, 0, 0), COORD_TOP, COORD_BOTTOM, '1, QUARTER);
        send_word(make_mode(AXIS_NONE, 0, 1), COORD_BOTTOM, COORD_TOP, 1, '1);
        send_word(make_mode(AXIS_NONE, 1, 0), 100, -100, 0, AW'(QUARTER / 2));
        send_word(make_mode(AXIS_NONE, 1, 1), COORD_TOP, COORD_TOP, COORD_TOP,
                  AW'(3 * QUARTER));

        // Let the pipeline run dry before the random part.
        drain_results();

        // Random words in bursts; gaps of zero leave long runs with no idling,
        // and gap lengths vary so pauses land on both pipeline stages.
        burst_left = 0;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                drain_results();
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                    pause_sender(gap);
                burst_left = $urandom_range(1, 24);
            end
            send_word(random_mode(), random_coord(), random_coord(), random_coord(),
                      random_angle());
            burst_left--;
        end

        // Wait out the last results, then wait on for any stray strobe.
        drain_results();
        repeat (8) @(posedge clk);
        if (bad_vectors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
